>>> rtl/core/tmap_pkg.sv
`default_nettype none

package tmap_pkg;

    // Table geometry
    localparam int TEMPO_ENTRIES = 64;
    localparam int ADDR_W        = $clog2(TEMPO_ENTRIES);
    localparam int CNT_W         = ADDR_W + 1;

    // Field widths
    localparam int TICK_W = 32;
    localparam int RATE_W = 24;
    localparam int TIME_W = 63;
    localparam int PROD_W = TICK_W + RATE_W;

    // Divider geometry: Q.16 numerator over a divisor below 2^25
    localparam int FRAC_W    = 16;
    localparam int NUM_W     = PROD_W + FRAC_W;
    localparam int DEN_W     = 25;
    localparam int DIV_STEP  = 4;
    localparam int DIV_ITER  = NUM_W / DIV_STEP;
    localparam int DIV_CNT_W = $clog2(DIV_ITER);

    // Configuration port
    localparam int CFG_W = 15;

    // Constants
    localparam logic [RATE_W-1:0] DEFAULT_TEMPO_US = 24'd500000;
    localparam logic [9:0]        MS_PER_S         = 10'd1000;

    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [CNT_W-1:0]  t_cnt;

    typedef enum logic {
        REQ_INSERT = 1'b0,
        REQ_QUERY  = 1'b1
    } t_req_type;

    typedef enum logic {
        MODE_METRICAL = 1'b0,
        MODE_SMPTE    = 1'b1
    } t_mode;

    typedef enum logic [1:0] {
        CFG_TIME_MODE       = 2'd0,
        CFG_TICKS_PER_BEAT  = 2'd1,
        CFG_FRAME_RATE      = 2'd2,
        CFG_TICKS_PER_FRAME = 2'd3
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INS_RD,
        ST_INS_CHK,
        ST_QRY_RD,
        ST_QRY_CHK,
        ST_MUL,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_DONE
    } t_state;

    typedef struct packed {
        t_req_type          req_type;
        logic [TICK_W-1:0]  tick;
        logic [RATE_W-1:0]  tempo_us;
    } t_req;

    typedef struct packed {
        logic [TIME_W-1:0] time_ms_q16;
        logic              status;
    } t_res;

    typedef struct packed {
        logic [TICK_W-1:0] tick;
        logic [RATE_W-1:0] rate;
    } t_entry;

endpackage

`default_nettype wire

>>> rtl/core/tmap_table.sv
`default_nettype none

module tmap_table (
    input  wire logic            i_clk,
    input  wire logic            i_we,
    input  wire tmap_pkg::t_addr i_waddr,
    input  wire tmap_pkg::t_entry i_wdata,
    input  wire logic            i_re,
    input  wire tmap_pkg::t_addr i_raddr,
    output tmap_pkg::t_entry     o_rdata
);
    import tmap_pkg::*;

    t_entry r_mem [TEMPO_ENTRIES];
    t_entry r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> rtl/core/tmap_div.sv
`default_nettype none

module tmap_div (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [tmap_pkg::NUM_W-1:0]  i_num,
    input  wire logic [tmap_pkg::DEN_W-1:0]  i_den,
    output logic                             o_done,
    output logic [tmap_pkg::NUM_W-1:0]       o_quot
);
    import tmap_pkg::*;

    logic [NUM_W-1:0]     r_num;
    logic [NUM_W-1:0]     n_num;
    logic [DEN_W-1:0]     r_den;
    logic [DEN_W-1:0]     r_rem;
    logic [DEN_W-1:0]     n_rem;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;

    // Retire DIV_STEP quotient bits per cycle; quotient shifts in behind the numerator
    always_comb begin
        logic [DEN_W:0]   rem_ext;
        logic [DEN_W-1:0] rem;
        logic [NUM_W-1:0] num;
        rem = r_rem;
        num = r_num;
        for (int k = 0; k < DIV_STEP; k++) begin
            rem_ext = {rem, num[NUM_W-1]};
            if (rem_ext >= {1'b0, r_den}) begin
                rem_ext = rem_ext - {1'b0, r_den};
                num     = {num[NUM_W-2:0], 1'b1};
            end else begin
                num     = {num[NUM_W-2:0], 1'b0};
            end
            rem = rem_ext[DEN_W-1:0];
        end
        n_rem = rem;
        n_num = num;
    end

    // Sequence control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_ITER - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Operand and remainder registers
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_num <= n_num;
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_num;

endmodule

`default_nettype wire

>>> rtl/core/midi_tempo_map_tick_to_time_top.sv
// Insert: dropped at once on a full table, else each entry with a later tick is moved up by one
// slot and the new change lands behind them (in slot zero when every entry is later).
// Query: in SMPTE mode a multiply, divider start and 18 four-bit divide steps; in metrical mode
// the same for each earlier change crossed and for the closing span (a repeated tick is skipped).
// One item at a time; the next item is taken while the last result waits in its output register.
// Synchronous active-low reset empties the tempo table and restores configuration defaults.
`default_nettype none

module midi_tempo_map_tick_to_time_top (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire tmap_pkg::t_cfg_idx          i_cfg_idx,
    input  wire logic [tmap_pkg::CFG_W-1:0]  i_cfg_data,
    input  wire logic                        i_req_valid,
    output logic                             o_req_ready,
    input  wire tmap_pkg::t_req              i_req,
    output logic                             o_res_valid,
    input  wire logic                        i_res_ready,
    output tmap_pkg::t_res                   o_res
);
    import tmap_pkg::*;

    // Configuration
    t_mode       r_time_mode;
    logic [14:0] r_tpb;
    logic [4:0]  r_fps;
    logic [7:0]  r_tpf;

    // Sequencer and datapath
    t_state              r_state;
    t_state              n_state;
    t_cnt                r_count;
    t_cnt                r_pos;
    t_cnt                r_idx;
    t_req_type           r_type;
    logic [TICK_W-1:0]   r_tick;
    logic [RATE_W-1:0]   r_us;
    logic [TICK_W-1:0]   r_prev;
    logic [RATE_W-1:0]   r_rate;
    logic [TICK_W-1:0]   r_delta;
    logic [RATE_W-1:0]   r_seg_rate;
    logic                r_last;
    logic [PROD_W-1:0]   r_prod;
    logic [DEN_W-1:0]    r_den;
    logic [TIME_W-1:0]   r_acc;
    logic                r_status;
    logic                r_res_valid;
    t_res                r_res;

    // Table and divider hookup
    logic        mem_we;
    t_addr       mem_waddr;
    t_entry      mem_wdata;
    logic        mem_re;
    t_addr       mem_raddr;
    t_entry      mem_rdata;
    logic        div_start;
    logic        div_done;
    logic [NUM_W-1:0] div_quot;

    logic        req_fire;
    logic        res_load;
    t_cnt        pos_m1;
    t_entry      new_entry;
    logic [RATE_W-1:0] cur_rate;
    logic [14:0] tpb_eff;
    logic [4:0]  fps_eff;
    logic [7:0]  tpf_eff;
    logic [DEN_W-1:0] den_met;
    logic [DEN_W-1:0] den_smpte;

    assign req_fire  = i_req_valid && o_req_ready;
    assign res_load  = (r_state == ST_DONE) && (!r_res_valid || i_res_ready);
    assign pos_m1    = r_pos - 1'b1;
    assign new_entry = '{tick: r_tick, rate: r_us};
    // Entry zero's tempo also covers the span before the first change
    assign cur_rate  = (r_idx == '0) ? mem_rdata.rate : r_rate;

    // Divisors, with a zero register treated as one
    assign tpb_eff   = (r_tpb == '0) ? 15'd1 : r_tpb;
    assign fps_eff   = (r_fps == '0) ? 5'd1 : r_fps;
    assign tpf_eff   = (r_tpf == '0) ? 8'd1 : r_tpf;
    assign den_met   = DEN_W'(tpb_eff * MS_PER_S);
    assign den_smpte = DEN_W'(fps_eff * tpf_eff);

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time_mode <= MODE_METRICAL;
            r_tpb       <= 15'd480;
            r_fps       <= 5'd25;
            r_tpf       <= 8'd40;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_TIME_MODE:       r_time_mode <= t_mode'(i_cfg_data[0]);
                CFG_TICKS_PER_BEAT:  r_tpb       <= i_cfg_data[14:0];
                CFG_FRAME_RATE:      r_fps       <= i_cfg_data[4:0];
                CFG_TICKS_PER_FRAME: r_tpf       <= i_cfg_data[7:0];
            endcase
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_req_valid) begin
                    if (i_req.req_type == REQ_INSERT) begin
                        n_state = (r_count == CNT_W'(TEMPO_ENTRIES)) ? ST_DONE : ST_INS_RD;
                    end else begin
                        n_state = (r_time_mode == MODE_SMPTE) ? ST_MUL : ST_QRY_RD;
                    end
                end
            end
            ST_INS_RD: begin
                n_state = (r_pos == '0) ? ST_DONE : ST_INS_CHK;
            end
            ST_INS_CHK: begin
                n_state = (mem_rdata.tick > r_tick) ? ST_INS_RD : ST_DONE;
            end
            ST_QRY_RD: begin
                n_state = (r_idx == r_count) ? ST_MUL : ST_QRY_CHK;
            end
            ST_QRY_CHK: begin
                if (mem_rdata.tick >= r_tick || mem_rdata.tick > r_prev) begin
                    n_state = ST_MUL;
                end else begin
                    n_state = ST_QRY_RD;
                end
            end
            ST_MUL:    n_state = ST_DIV_GO;
            ST_DIV_GO: n_state = ST_DIV_WAIT;
            ST_DIV_WAIT: begin
                if (div_done) begin
                    n_state = r_last ? ST_DONE : ST_QRY_RD;
                end
            end
            ST_DONE: begin
                if (res_load) begin
                    n_state = ST_IDLE;
                end
            end
        endcase
    end

    // Control outputs
    always_comb begin
        o_req_ready = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = r_pos[ADDR_W-1:0];
        mem_wdata   = new_entry;
        mem_re      = 1'b0;
        mem_raddr   = r_idx[ADDR_W-1:0];
        div_start   = 1'b0;
        unique case (r_state)
            ST_IDLE: o_req_ready = 1'b1;
            ST_INS_RD: begin
                if (r_pos == '0) begin
                    mem_we = 1'b1;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = pos_m1[ADDR_W-1:0];
                end
            end
            ST_INS_CHK: begin
                // Move the later entry up one slot, or drop the new one in
                mem_we = 1'b1;
                if (mem_rdata.tick > r_tick) begin
                    mem_wdata = mem_rdata;
                end
            end
            ST_QRY_RD: begin
                mem_re = (r_idx != r_count);
            end
            ST_QRY_CHK:  ;
            ST_MUL:      ;
            ST_DIV_GO:   div_start = 1'b1;
            ST_DIV_WAIT: ;
            ST_DONE:     ;
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            if ((r_state == ST_INS_RD && r_pos == '0) ||
                (r_state == ST_INS_CHK && !(mem_rdata.tick > r_tick))) begin
                r_count <= r_count + 1'b1;
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                if (req_fire) begin
                    r_type     <= i_req.req_type;
                    r_tick     <= i_req.tick;
                    r_us       <= i_req.tempo_us;
                    r_acc      <= '0;
                    r_status   <= (i_req.req_type == REQ_INSERT) &&
                                  (r_count == CNT_W'(TEMPO_ENTRIES));
                    r_pos      <= r_count;
                    r_idx      <= '0;
                    r_prev     <= '0;
                    r_rate     <= DEFAULT_TEMPO_US;
                    r_den      <= (r_time_mode == MODE_SMPTE) ? den_smpte : den_met;
                    r_delta    <= i_req.tick;
                    r_seg_rate <= RATE_W'(MS_PER_S);
                    r_last     <= 1'b1;
                end
            end
            ST_INS_RD: ;
            ST_INS_CHK: begin
                if (mem_rdata.tick > r_tick) begin
                    r_pos <= pos_m1;
                end
            end
            ST_QRY_RD: begin
                // Table exhausted: close with the span up to the queried tick
                if (r_idx == r_count) begin
                    r_delta    <= r_tick - r_prev;
                    r_seg_rate <= r_rate;
                    r_last     <= 1'b1;
                end
            end
            ST_QRY_CHK: begin
                r_seg_rate <= cur_rate;
                if (mem_rdata.tick >= r_tick) begin
                    r_delta <= r_tick - r_prev;
                    r_last  <= 1'b1;
                end else begin
                    r_delta <= mem_rdata.tick - r_prev;
                    r_last  <= 1'b0;
                    r_prev  <= mem_rdata.tick;
                    r_rate  <= mem_rdata.rate;
                    r_idx   <= r_idx + 1'b1;
                end
            end
            ST_MUL: begin
                r_prod <= r_delta * r_seg_rate;
            end
            ST_DIV_GO: ;
            ST_DIV_WAIT: begin
                if (div_done) begin
                    r_acc <= r_acc + div_quot[TIME_W-1:0];
                end
            end
            ST_DONE: ;
        endcase
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (res_load) begin
            r_res_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_res_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_load) begin
            r_res.time_ms_q16 <= (r_type == REQ_QUERY) ? r_acc : '0;
            r_res.status      <= r_status;
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    tmap_table u_table (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    tmap_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   ({r_prod, {FRAC_W{1'b0}}}),
        .i_den   (r_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

endmodule

`default_nettype wire

>>> dv/tb_midi_tempo_map_tick_to_time_top.sv
`timescale 1ns / 1ps

module tb_midi_tempo_map_tick_to_time_top;
    import tmap_pkg::*;

    localparam int CYCLE_LIMIT = 10_000_000;
    localparam int LONG_HOLD   = 400;
    localparam int PHASE_ITEMS = 125;
    localparam int TAIL_CYCLES = 50;

    // Clock, reset and block inputs, all known from time zero
    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             i_cfg_we    = 1'b0;
    t_cfg_idx         i_cfg_idx   = CFG_TIME_MODE;
    logic [CFG_W-1:0] i_cfg_data  = '0;
    logic             i_req_valid = 1'b0;
    t_req             i_req       = '0;
    logic             i_res_ready = 1'b0;
    logic             o_req_ready;
    logic             o_res_valid;
    t_res             o_res;

    midi_tempo_map_tick_to_time_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_req       (i_req),
        .o_res_valid (o_res_valid),
        .i_res_ready (i_res_ready),
        .o_res       (o_res)
    );

    always #1 i_clk = ~i_clk;

    // Tempo map mirror and register copies
    bit [TICK_W-1:0] map_tick [TEMPO_ENTRIES];
    bit [RATE_W-1:0] map_us   [TEMPO_ENTRIES];
    int              map_len  = 0;
    t_mode           cfg_mode = MODE_METRICAL;
    bit [14:0]       cfg_tpb  = 15'd480;
    bit [4:0]        cfg_fps  = 5'd25;
    bit [7:0]        cfg_tpf  = 8'd40;

    // Items waiting to be sent and results still owed by the block
    t_req pending_reqs[$];
    t_res owed_results[$];

    logic req_taken = 1'b0;
    logic res_taken = 1'b0;
    int   errors    = 0;
    int   n_results = 0;
    int   n_ins     = 0;
    int   n_drop    = 0;
    int   n_qry     = 0;
    int   n_frame   = 0;
    int   n_settings = 1;
    int   hold_ask  = 0;
    int   cycle_cnt = 0;

    // floor(num * 2^16 / den), wrapping at 64 bits
    function automatic bit [63:0] frac_div(bit [63:0] num, bit [63:0] den);
        bit [63:0] q;
        bit [63:0] r;
        q = num / den;
        r = num % den;
        return (q << 16) + ((r << 16) / den);
    endfunction

    // Sum tempo segments from tick zero up to the queried tick
    function automatic bit [63:0] metric_ms(bit [31:0] tick);
        bit [63:0] den;
        bit [63:0] acc;
        bit [31:0] prev;
        bit [23:0] us;
        int        i;
        den  = ((cfg_tpb == 0) ? 64'd1 : 64'(cfg_tpb)) * 64'd1000;
        acc  = '0;
        prev = '0;
        if (tick == 0)
            return '0;
        us = (map_len != 0) ? map_us[0] : DEFAULT_TEMPO_US;
        for (i = 0; i < map_len; i++) begin
            if (map_tick[i] >= tick)
                break;
            if (map_tick[i] > prev)
                acc += frac_div(64'(map_tick[i] - prev) * 64'(us), den);
            prev = map_tick[i];
            us   = map_us[i];
        end
        acc += frac_div(64'(tick - prev) * 64'(us), den);
        return acc;
    endfunction

    function automatic bit [63:0] frame_ms(bit [31:0] tick);
        bit [63:0] fps;
        bit [63:0] tpf;
        fps = (cfg_fps == 0) ? 64'd1 : 64'(cfg_fps);
        tpf = (cfg_tpf == 0) ? 64'd1 : 64'(cfg_tpf);
        return frac_div(64'(tick) * 64'd1000, fps * tpf);
    endfunction

    // Insert after every entry with an equal or lower tick; drop when full
    function automatic bit tempo_add(bit [31:0] tick, bit [23:0] us);
        int pos;
        int j;
        if (map_len >= TEMPO_ENTRIES)
            return 1'b1;
        pos = map_len;
        while (pos > 0 && map_tick[pos-1] > tick)
            pos--;
        for (j = map_len; j > pos; j--) begin
            map_tick[j] = map_tick[j-1];
            map_us[j]   = map_us[j-1];
        end
        map_tick[pos] = tick;
        map_us[pos]   = us;
        map_len++;
        return 1'b0;
    endfunction

    function automatic t_res tempo_map_apply(t_req r);
        t_res e;
        e = '0;
        if (r.req_type == REQ_INSERT)
            e.status = tempo_add(r.tick, r.tempo_us);
        else if (cfg_mode == MODE_SMPTE)
            e.time_ms_q16 = TIME_W'(frame_ms(r.tick));
        else
            e.time_ms_q16 = TIME_W'(metric_ms(r.tick));
        return e;
    endfunction

    // Per-item wait: drawn at random, now and then a run of items with none
    function automatic int draw_wait(inout int run);
        if (run > 0) begin
            run--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            run = $urandom_range(8, 40);
            return 0;
        end
        return $urandom_range(0, 6);
    endfunction

    function automatic void log_error(string what);
        errors++;
        if (errors <= 10)
            $display("MISMATCH: %s", what);
    endfunction

    // Driver: hold an offered item until taken, then wait and offer the next
    int send_gap = 0;
    int send_run = 0;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_req_valid <= 1'b0;
        end else if (i_req_valid && !req_taken) begin
            // hold
        end else if (send_gap > 0) begin
            i_req_valid <= 1'b0;
            send_gap--;
        end else if (pending_reqs.size() != 0) begin
            i_req       <= pending_reqs.pop_front();
            i_req_valid <= 1'b1;
            send_gap = draw_wait(send_run);
        end else begin
            i_req_valid <= 1'b0;
        end
    end

    // Receiver: random stalls per result, plus a long hold-off on request
    int recv_wait  = 0;
    int recv_run   = 0;
    int stall_left = 0;
    int hold_seen  = 0;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_res_ready <= 1'b0;
        end else if (stall_left > 0) begin
            i_res_ready <= 1'b0;
            stall_left--;
        end else if (hold_seen != hold_ask) begin
            hold_seen = hold_ask;
            stall_left = LONG_HOLD;
            i_res_ready <= 1'b0;
        end else begin
            if (res_taken)
                recv_wait = draw_wait(recv_run);
            if (recv_wait > 0) begin
                i_res_ready <= 1'b0;
                recv_wait--;
            end else begin
                i_res_ready <= 1'b1;
            end
        end
    end

    // Monitor: predict on every accepted item, check every accepted result
    always @(posedge i_clk) begin
        t_res want;
        if (!i_rst_n) begin
            req_taken <= 1'b0;
            res_taken <= 1'b0;
        end else begin
            req_taken <= i_req_valid && o_req_ready;
            res_taken <= o_res_valid && i_res_ready;
            if (i_req_valid && o_req_ready) begin
                want = tempo_map_apply(i_req);
                owed_results.push_back(want);
                if (i_req.req_type == REQ_INSERT) begin
                    n_ins++;
                    if (want.status)
                        n_drop++;
                end else begin
                    n_qry++;
                    if (cfg_mode == MODE_SMPTE)
                        n_frame++;
                end
            end
            if (o_res_valid && i_res_ready) begin
                n_results++;
                if (owed_results.size() == 0) begin
                    log_error($sformatf("result %0d arrived with none expected: time %0h status %0b",
                                        n_results, o_res.time_ms_q16, o_res.status));
                end else begin
                    want = owed_results.pop_front();
                    if (o_res.time_ms_q16 !== want.time_ms_q16 || o_res.status !== want.status)
                        log_error($sformatf({"result %0d: expected time %0h status %0b, ",
                                             "got time %0h status %0b"},
                                            n_results, want.time_ms_q16, want.status,
                                            o_res.time_ms_q16, o_res.status));
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding",
                     cycle_cnt, owed_results.size());
            $display("tb_midi_tempo_map_tick_to_time_top: errors");
            $finish;
        end
    end

    task automatic push_item(t_req_type kind, bit [31:0] tick, bit [23:0] us);
        t_req r;
        r.req_type = kind;
        r.tick     = tick;
        r.tempo_us = us;
        pending_reqs.push_back(r);
    endtask

    // Write one register; only called while the block is idle
    task automatic cfg_write(t_cfg_idx idx, int unsigned val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= CFG_W'(val);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_TIME_MODE:       cfg_mode = t_mode'(val & 1);
            CFG_TICKS_PER_BEAT:  cfg_tpb  = 15'(val);
            CFG_FRAME_RATE:      cfg_fps  = 5'(val);
            CFG_TICKS_PER_FRAME: cfg_tpf  = 8'(val);
            default: ;
        endcase
    endtask

    task automatic set_all(int unsigned m, int unsigned tpb, int unsigned fps,
                           int unsigned tpf);
        cfg_write(CFG_TIME_MODE, m);
        cfg_write(CFG_TICKS_PER_BEAT, tpb);
        cfg_write(CFG_FRAME_RATE, fps);
        cfg_write(CFG_TICKS_PER_FRAME, tpf);
        n_settings++;
    endtask

    // Wait until every item is taken and every result has come back
    task automatic drain(int extra);
        while (pending_reqs.size() != 0 || i_req_valid || owed_results.size() != 0)
            @(posedge i_clk);
        repeat (extra) @(posedge i_clk);
    endtask

    initial begin
        int          p;
        int          k;
        int          sel;
        int unsigned m;
        int unsigned tpb;
        int unsigned fps;
        int unsigned tpf;
        bit [31:0]   tk;
        bit [23:0]   us;

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Empty map, default tempo, then the first changes and edge ticks
        push_item(REQ_QUERY, 32'd0, 24'($urandom));
        push_item(REQ_QUERY, 32'd480, 24'($urandom));
        push_item(REQ_QUERY, 32'hFFFF_FFFF, 24'($urandom));
        push_item(REQ_INSERT, 32'd1000, 24'hFF_FFFF);
        push_item(REQ_QUERY, 32'd500, 24'($urandom));
        push_item(REQ_INSERT, 32'd1000, 24'd0);
        push_item(REQ_QUERY, 32'd1000, 24'($urandom));
        push_item(REQ_QUERY, 32'd1001, 24'($urandom));
        push_item(REQ_INSERT, 32'd0, 24'd250000);
        push_item(REQ_QUERY, 32'd1, 24'($urandom));
        push_item(REQ_INSERT, 32'hFFFF_FFFF, 24'd1);
        push_item(REQ_QUERY, 32'hFFFF_FFFF, 24'($urandom));
        push_item(REQ_QUERY, 32'hFFFF_FFFE, 24'($urandom));
        drain(8);

        // Frame based timing at reset rates, then zero and top divisors, then a zero beat divisor
        cfg_write(CFG_TIME_MODE, MODE_SMPTE);
        n_settings++;
        push_item(REQ_QUERY, 32'd0, 24'($urandom));
        push_item(REQ_QUERY, 32'hFFFF_FFFF, 24'($urandom));
        push_item(REQ_QUERY, 32'd12345, 24'($urandom));
        push_item(REQ_INSERT, 32'd1000, 24'd123);
        drain(8);
        set_all(MODE_SMPTE, 480, 0, 0);
        push_item(REQ_QUERY, 32'hFFFF_FFFF, 24'($urandom));
        push_item(REQ_QUERY, 32'd777, 24'($urandom));
        drain(8);
        set_all(MODE_SMPTE, 480, 31, 255);
        push_item(REQ_QUERY, 32'hFFFF_FFFF, 24'($urandom));
        drain(8);
        set_all(MODE_METRICAL, 0, 25, 40);
        push_item(REQ_QUERY, 32'hFFFF_FFFF, 24'($urandom));
        push_item(REQ_QUERY, 32'd5000, 24'($urandom));
        drain(8);

        // Random phases: extremes first, then random settings
        for (p = 0; p < 8; p++) begin
            case (p)
                0: begin m = MODE_METRICAL; tpb = 1;     fps = 24; tpf = 1;   end
                1: begin m = MODE_SMPTE;    tpb = 32767; fps = 24; tpf = 1;   end
                2: begin m = MODE_METRICAL; tpb = 32767; fps = 30; tpf = 255; end
                3: begin m = MODE_SMPTE;    tpb = 1;     fps = 30; tpf = 255; end
                default: begin
                    m   = $urandom_range(0, 1);
                    tpb = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 32767);
                    fps = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 31)
                                                      : $urandom_range(24, 30);
                    tpf = $urandom_range(0, 255);
                end
            endcase
            set_all(m, tpb, fps, tpf);

            for (k = 0; k < PHASE_ITEMS; k++) begin
                sel = $urandom_range(0, 9);
                if ($urandom_range(0, 99) < 20) begin
                    // Tempo change: spread ticks, repeats of existing ticks, small ticks
                    if (sel <= 5 || (sel <= 7 && map_len == 0))
                        tk = $urandom;
                    else if (sel <= 7)
                        tk = map_tick[$urandom_range(0, map_len - 1)];
                    else if (sel == 8)
                        tk = $urandom_range(0, 4095);
                    else
                        tk = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0;
                    us = ($urandom_range(0, 3) == 0) ? 24'($urandom_range(300000, 1000000))
                                                     : 24'($urandom);
                    push_item(REQ_INSERT, tk, us);
                end else begin
                    // Conversion: anywhere, right around a change, or near the start
                    if (sel <= 3 || (sel <= 6 && map_len == 0))
                        tk = $urandom;
                    else if (sel <= 6)
                        tk = map_tick[$urandom_range(0, map_len - 1)]
                             + 32'($urandom_range(0, 2)) - 32'd1;
                    else if (sel <= 8)
                        tk = $urandom_range(0, 100000);
                    else
                        tk = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd1;
                    push_item(REQ_QUERY, tk, 24'($urandom));
                end
            end

            // Back the result side up while items keep coming
            if (p == 2 || p == 5)
                hold_ask++;
            drain(8);
        end

        drain(TAIL_CYCLES);
        $display("Covered %0d tempo changes (%0d dropped on a full map) and %0d conversions",
                 n_ins, n_drop, n_qry);
        $display("(%0d frame based) over %0d register settings; %0d mismatches in %0d results",
                 n_frame, n_settings, errors, n_results);
        if (errors == 0)
            $display("tb_midi_tempo_map_tick_to_time_top: clean");
        else
            $display("tb_midi_tempo_map_tick_to_time_top: errors");
        $finish;
    end

endmodule
